FILE: sv/utrb_pkg.sv
package utrb_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int BYTE_W          = 8;

    // Item kinds; the fourth code changes nothing
    typedef enum logic [1:0] {
        KIND_SEND = 2'd0,
        KIND_RECV = 2'd1,
        KIND_LINE = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic              line_ready;
        logic              rx_event;
        logic              tx_event;
    } in_item_t;

    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              read_valid;
        logic [BYTE_W-1:0] read_byte;
        logic              tx_dropped;
        logic              rx_dropped;
        logic              last;
    } res_item_t;

endpackage

FILE: sv/utrb_ram.sv
module utrb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write one entry, read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/uart_tx_rx_ring_buffers_top.sv
// Channel   | Handshake            | Payload                | Notes
// ----------+----------------------+------------------------+---------------------------
// item in   | start, busy          | item   (in_item_t)     | transfer when start & !busy
// result    | done                 | result (res_item_t)    | one cycle, cannot stall
// config    | cfg_write            | cfg_data               | echo enable, write only
//
// One item per cycle; busy stays low. Each item passes the input register, then the result
// register, and it always gives its result as one result
// with last set. The queue RAMs keep this pace: each has a registered read whose address
// is the next head, with a one-entry forward for a write to that same entry.
// Reset empties both queues and clears echo enable; the queue RAMs are not cleared.
// The receiver cannot stall, so there is no result buffering beyond the result register.
module uart_tx_rx_ring_buffers_top #(
    parameter int QUEUE_DEPTH = utrb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  utrb_pkg::in_item_t item,
    output logic               done,
    output utrb_pkg::res_item_t result,
    input  logic               cfg_write,
    input  logic               cfg_data
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        nxt = idx + IDX_W'(1);
        return (idx == LAST_IDX) ? '0 : nxt;
    endfunction

    // Input and result registers
    utrb_pkg::in_item_t  item_reg;
    logic                item_valid_reg;
    utrb_pkg::res_item_t result_reg, result_next;
    logic                done_reg;
    logic                echo_enable_reg;

    // Queue pointers
    logic [IDX_W-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [CNT_W-1:0] tx_count_reg, tx_count_next;
    logic [IDX_W-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [CNT_W-1:0] rx_count_reg, rx_count_next;

    // RAM ports and head forwarding
    logic                        tx_we, rx_we;
    logic [utrb_pkg::BYTE_W-1:0] tx_q, rx_q;
    logic                        tx_fwd_reg, rx_fwd_reg;
    logic [utrb_pkg::BYTE_W-1:0] tx_fwd_data_reg, rx_fwd_data_reg;
    logic [utrb_pkg::BYTE_W-1:0] tx_head_byte, rx_head_byte;

    // Work signals
    logic             tx_want, tx_push, tx_imm, tx_pop;
    logic             rx_push;
    logic [CNT_W-1:0] tx_count_pushed;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    assign tx_head_byte = tx_fwd_reg ? tx_fwd_data_reg : tx_q;
    assign rx_head_byte = rx_fwd_reg ? rx_fwd_data_reg : rx_q;

    // Compute queue updates and the result for the registered item
    always_comb
    begin
        tx_want         = 1'b0;
        tx_push         = 1'b0;
        tx_imm          = 1'b0;
        tx_pop          = 1'b0;
        rx_push         = 1'b0;
        tx_count_pushed = tx_count_reg;
        rx_head_next    = rx_head_reg;
        rx_tail_next    = rx_tail_reg;
        rx_count_next   = rx_count_reg;
        result_next     = '0;
        result_next.last = 1'b1;

        if (item_valid_reg)
        begin
            case (item_reg.kind)
                utrb_pkg::KIND_SEND:
                begin
                    tx_want = 1'b1;
                end
                utrb_pkg::KIND_RECV:
                begin
                    if (rx_count_reg != '0)
                    begin
                        result_next.read_valid = 1'b1;
                        result_next.read_byte  = rx_head_byte;
                        rx_head_next  = wrap_inc(rx_head_reg);
                        rx_count_next = rx_count_reg - CNT_W'(1);
                    end
                end
                utrb_pkg::KIND_LINE:
                begin
                    if (item_reg.rx_event)
                    begin
                        if (rx_count_reg < FULL_CNT)
                        begin
                            rx_push       = 1'b1;
                            rx_tail_next  = wrap_inc(rx_tail_reg);
                            rx_count_next = rx_count_reg + CNT_W'(1);
                            tx_want       = echo_enable_reg;
                        end
                        else
                        begin
                            result_next.rx_dropped = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // Queue for transmit or drop, then start the line on a lone byte
            if (tx_want)
            begin
                if (tx_count_reg < FULL_CNT)
                begin
                    tx_push         = 1'b1;
                    tx_count_pushed = tx_count_reg + CNT_W'(1);
                end
                else
                begin
                    result_next.tx_dropped = 1'b1;
                end
                tx_imm = item_reg.line_ready && (tx_count_pushed == CNT_W'(1));
            end

            // Transmit request takes the head after any echo
            tx_pop = (item_reg.kind == utrb_pkg::KIND_LINE) && item_reg.tx_event
                     && !tx_imm && (tx_count_pushed != '0);

            if (tx_imm || tx_pop)
            begin
                result_next.tx_valid = 1'b1;
                result_next.tx_byte  = (tx_count_reg == '0) ? item_reg.data_byte
                                                             : tx_head_byte;
            end
        end

        tx_tail_next  = tx_push ? wrap_inc(tx_tail_reg) : tx_tail_reg;
        tx_head_next  = (tx_imm || tx_pop) ? wrap_inc(tx_head_reg) : tx_head_reg;
        tx_count_next = tx_count_pushed - CNT_W'(tx_imm || tx_pop);
    end

    assign tx_we = tx_push;
    assign rx_we = rx_push;

    utrb_ram #(
        .DATA_W (utrb_pkg::BYTE_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_tail_reg),
        .wdata (item_reg.data_byte),
        .raddr (tx_head_next),
        .rdata (tx_q)
    );

    utrb_ram #(
        .DATA_W (utrb_pkg::BYTE_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_tail_reg),
        .wdata (item_reg.data_byte),
        .raddr (rx_head_next),
        .rdata (rx_q)
    );

    // Hold a write that lands on the entry being read, and register the item and the result
    always_ff @(posedge clk)
    begin
        tx_fwd_data_reg <= item_reg.data_byte;
        rx_fwd_data_reg <= item_reg.data_byte;
        item_reg        <= item;
        result_reg      <= result_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            done_reg        <= 1'b0;
            echo_enable_reg <= 1'b0;
            tx_fwd_reg      <= 1'b0;
            rx_fwd_reg      <= 1'b0;
            tx_head_reg     <= '0;
            tx_tail_reg     <= '0;
            tx_count_reg    <= '0;
            rx_head_reg     <= '0;
            rx_tail_reg     <= '0;
            rx_count_reg    <= '0;
        end
        else
        begin
            item_valid_reg <= start && !busy;
            done_reg       <= item_valid_reg;
            if (cfg_write)
            begin
                echo_enable_reg <= cfg_data;
            end
            tx_fwd_reg   <= tx_we && (tx_tail_reg == tx_head_next);
            rx_fwd_reg   <= rx_we && (rx_tail_reg == rx_head_next);
            tx_head_reg  <= tx_head_next;
            tx_tail_reg  <= tx_tail_next;
            tx_count_reg <= tx_count_next;
            rx_head_reg  <= rx_head_next;
            rx_tail_reg  <= rx_tail_next;
            rx_count_reg <= rx_count_next;
        end
    end

    // Checks
    a_tx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tx_count_reg <= FULL_CNT)
        else $error("tx queue count beyond depth");

    a_rx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_count_reg <= FULL_CNT)
        else $error("rx queue count beyond depth");

    a_tx_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_count_reg == '0) |-> (tx_head_reg == tx_tail_reg))
        else $error("empty tx queue with head and tail apart");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted item produced no result");

endmodule
